FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LDDN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lddn assertion failed");

// next-cycle implication, disabled while reset is asserted
`define LDDN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lddn assertion failed");

`endif

FILE: rtl/lddn_pkg.sv
// shared constants, codes and types of the difference denoiser
`default_nettype none

package lddn_pkg;

  // sample and difference formats
  localparam int SAMPLE_BITS     = 16;
  localparam int SAMPLE_FRAC     = SAMPLE_BITS - 1;
  localparam int DIFF_BITS       = SAMPLE_BITS + 1;
  localparam int T_BITS          = SAMPLE_BITS + 1;

  // mean format and conversion from the sample format
  localparam int MEAN_BITS       = 24;
  localparam int MEAN_FRAC       = MEAN_BITS - 3;
  localparam int MEAN_SHIFT      = MEAN_FRAC - SAMPLE_FRAC;
  localparam int DM_BITS         = DIFF_BITS + MEAN_SHIFT;
  localparam int DIFF_M_BITS     = MEAN_BITS + 1;

  // channel history store
  localparam int MAX_CHANNELS    = 256;
  localparam int CHAN_BITS       = $clog2(MAX_CHANNELS);
  localparam int CHAN_COUNT_BITS = 9;
  localparam int CHAN_WORD_BITS  = DIFF_BITS + SAMPLE_BITS;

  // bin store
  localparam int TABLE_BINS      = 4096;
  localparam int BIN_BITS        = $clog2(TABLE_BINS);
  localparam int BIN_PROD_BITS   = T_BITS + BIN_BITS;
  localparam int COUNT_BITS      = 32;
  localparam int BIN_WORD_BITS   = COUNT_BITS + MEAN_BITS;

  // gain and blend arithmetic
  localparam int GAIN_BITS       = 17;
  localparam int GAIN_FRAC       = 16;
  localparam int GAIN_ONE        = 1 << GAIN_FRAC;
  localparam int BLEND_SHIFT     = MEAN_FRAC + GAIN_FRAC - SAMPLE_FRAC;
  localparam int PROD_A_BITS     = GAIN_BITS + 1 + DIFF_BITS;
  localparam int PROD_BITS       = GAIN_BITS + 1 + MEAN_BITS;
  localparam int ACC_BITS        = 44;
  localparam int Y_BITS          = ACC_BITS - BLEND_SHIFT;

  // running-mean divider: the quotient never exceeds the magnitude of the difference from the mean
  localparam int QUO_BITS        = MEAN_BITS;
  localparam int DIVIDEND_BITS   = COUNT_BITS;

  // configuration port
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 17;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEARN_OR_APPLY = 2'd0;
  localparam cfg_idx_t CFG_CHANNEL_COUNT  = 2'd1;
  localparam cfg_idx_t CFG_BLEND_GAIN     = 2'd2;

  localparam logic MODE_LEARN = 1'b0;
  localparam logic MODE_APPLY = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN,
    S_MUL,
    S_DIV,
    S_WB,
    S_MUL2,
    S_EMIT
  } lddn_state_e;

endpackage

`default_nettype wire

FILE: rtl/learned_difference_denoiser.sv
// top level of the learned difference denoiser: sequencer, datapath and stores
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tdata: sample; tuser: start_of_pass
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata: cleaned_sample; tuser: chan, clipped
// cfg      in   cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// a learn word runs through the 24-step running-mean divider before the bin write-back
// an apply word passes through channel read, bin read, two gain products and blend
// after reset all 4096 bins of the bin store are cleared with s_axis_tready low
// a finished result waits in the output register while the next word is taken
// in apply mode the sequencer holds in its last state while that register is full and m_axis_tready is low
`default_nettype none
`include "assert_macros.svh"

module learned_difference_denoiser
  import lddn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,   // [15:0] sample
  input  logic                     s_axis_tuser,   // [0] start_of_pass
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [SAMPLE_BITS-1:0]   m_axis_tdata,   // [15:0] cleaned_sample
  output logic [CHAN_BITS:0]       m_axis_tuser    // [7:0] channel_index, [8] clipped
);

  lddn_state_e state_q, state_d;

  // configuration registers
  logic                       learn_q;
  logic [CHAN_COUNT_BITS-1:0] chan_count_q;
  logic [GAIN_BITS-1:0]       gain_q;

  // channel rotation and history valid bits
  logic [CHAN_BITS-1:0]       pos_q, pos_d;
  logic [MAX_CHANNELS-1:0]    valid_q;
  logic [BIN_BITS-1:0]        clr_addr_q;

  // per-word working registers
  logic [CHAN_BITS-1:0]         c_q;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;
  logic signed [DIFF_BITS-1:0]  d_q;
  logic [BIN_BITS-1:0]          bin_q;
  logic [COUNT_BITS-1:0]        n_q;
  logic                         neg_q;
  logic signed [MEAN_BITS-1:0]  mean_q;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [ACC_BITS-1:0]   acc_q;

  // output register
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic [CHAN_BITS-1:0]   out_chan_q;
  logic                   out_clip_q;

  // sequencer outputs
  logic accept;
  logic chan_we;
  logic bin_re;
  logic bin_we;
  logic div_start;
  logic out_load;

  // store ports
  logic [CHAN_BITS-1:0]      chan_raddr;
  logic [CHAN_WORD_BITS-1:0] chan_rdata;
  logic [BIN_BITS-1:0]       bin_waddr;
  logic [BIN_WORD_BITS-1:0]  bin_wdata;
  logic [BIN_WORD_BITS-1:0]  bin_rdata;

  // divider
  logic                     div_done;
  logic [QUO_BITS-1:0]      div_quo;
  logic [DIVIDEND_BITS-1:0] dividend;

  // channel stage
  logic [SAMPLE_BITS-1:0]       prev_rd;
  logic signed [DIFF_BITS-1:0]  pd_rd;
  logic signed [DIFF_BITS-1:0]  d_calc;
  logic signed [DIFF_BITS:0]    t_raw;
  logic [T_BITS-1:0]            t_cl;
  logic [BIN_PROD_BITS-1:0]     bin_prod;
  logic [BIN_BITS-1:0]          bin_calc;
  logic [CHAN_COUNT_BITS-1:0]   cnt_eff;
  logic [CHAN_COUNT_BITS-1:0]   c_inc;

  // bin stage
  logic [COUNT_BITS-1:0]          count_rd;
  logic signed [MEAN_BITS-1:0]    mean_rd;
  logic [COUNT_BITS-1:0]          n_calc;
  logic signed [DM_BITS-1:0]      dm;
  logic signed [DIFF_M_BITS-1:0]  diff_m;
  logic [DIFF_M_BITS-1:0]         mag_full;
  logic [GAIN_BITS-1:0]           kc;
  logic [GAIN_BITS-1:0]           one_minus;
  logic signed [PROD_A_BITS-1:0]  prod_a;
  logic signed [PROD_BITS-1:0]    prod_b;
  logic signed [ACC_BITS-1:0]     acc_d;

  // write-back and blend result
  logic signed [MEAN_BITS+1:0]  mean_ext;
  logic signed [MEAN_BITS+1:0]  q_ext;
  logic signed [MEAN_BITS+1:0]  mean_sum;
  logic [MEAN_BITS-1:0]         mean_new;
  logic signed [ACC_BITS-1:0]   total;
  logic [Y_BITS-1:0]            y;
  logic [SAMPLE_BITS-1:0]       y_sat;
  logic                         y_clip;

  assign accept = s_axis_tvalid && s_axis_tready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q      <= MODE_LEARN;
      chan_count_q <= CHAN_COUNT_BITS'(1);
      gain_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LEARN_OR_APPLY: learn_q      <= cfg_wdata_i[0];
        CFG_CHANNEL_COUNT:  chan_count_q <= cfg_wdata_i[CHAN_COUNT_BITS-1:0];
        CFG_BLEND_GAIN:     gain_q       <= cfg_wdata_i[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_addr_q == '1) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_BIN;
      S_BIN:   state_d = S_MUL;
      S_MUL:   state_d = (learn_q == MODE_LEARN) ? S_DIV : S_MUL2;
      S_DIV:   if (div_done) state_d = S_WB;
      S_WB:    state_d = S_IDLE;
      S_MUL2:  state_d = S_EMIT;
      S_EMIT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    chan_we       = 1'b0;
    bin_re        = 1'b0;
    bin_we        = 1'b0;
    div_start     = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      S_CLEAR: bin_we = 1'b1;
      S_IDLE:  s_axis_tready = 1'b1;
      S_BIN: begin
        chan_we = 1'b1;
        bin_re  = 1'b1;
      end
      S_MUL:   div_start = (learn_q == MODE_LEARN);
      S_DIV:   ;
      S_WB:    bin_we = 1'b1;
      S_MUL2:  ;
      S_EMIT:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // clearing pass over the bin store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (state_q == S_CLEAR) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // channel history store: {difference, sample}
  assign chan_raddr = s_axis_tuser ? '0 : pos_q;

  lddn_ram #(
    .ADDR_BITS (CHAN_BITS),
    .DATA_BITS (CHAN_WORD_BITS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (c_q),
    .wdata_i ({d_calc, x_q}),
    .re_i    (accept),
    .raddr_i (chan_raddr),
    .rdata_o (chan_rdata)
  );

  // previous sample and difference, zero for a channel without history
  assign prev_rd = valid_q[c_q] ? chan_rdata[SAMPLE_BITS-1:0] : '0;
  assign pd_rd   = valid_q[c_q] ? chan_rdata[CHAN_WORD_BITS-1:SAMPLE_BITS] : '0;
  assign d_calc  = {x_q[SAMPLE_BITS-1], x_q} - {prev_rd[SAMPLE_BITS-1], prev_rd};

  // bin index from the clamped previous difference
  assign t_raw = {pd_rd[DIFF_BITS-1], pd_rd} + (DIFF_BITS+1)'(1 << SAMPLE_FRAC);

  always_comb begin
    if (t_raw[DIFF_BITS]) begin
      t_cl = '0;
    end else if (t_raw[T_BITS-1:0] > T_BITS'(2 << SAMPLE_FRAC)) begin
      t_cl = T_BITS'(2 << SAMPLE_FRAC);
    end else begin
      t_cl = t_raw[T_BITS-1:0];
    end
  end

  assign bin_prod = BIN_PROD_BITS'(t_cl) * BIN_PROD_BITS'(TABLE_BINS - 1);
  assign bin_calc = bin_prod[SAMPLE_FRAC+1 +: BIN_BITS];

  // channel rotation
  always_comb begin
    if (chan_count_q == '0) begin
      cnt_eff = CHAN_COUNT_BITS'(1);
    end else if (chan_count_q > CHAN_COUNT_BITS'(MAX_CHANNELS)) begin
      cnt_eff = CHAN_COUNT_BITS'(MAX_CHANNELS);
    end else begin
      cnt_eff = chan_count_q;
    end
  end

  assign c_inc = CHAN_COUNT_BITS'(c_q) + 1'b1;
  assign pos_d = (c_inc >= cnt_eff) ? '0 : c_inc[CHAN_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      valid_q <= '0;
    end else if (accept && s_axis_tuser) begin
      valid_q <= '0;
    end else if (state_q == S_BIN) begin
      pos_q          <= pos_d;
      valid_q[c_q]   <= 1'b1;
    end
  end

  // bin store: {count, mean}
  assign bin_waddr = (state_q == S_CLEAR) ? clr_addr_q : bin_q;
  assign bin_wdata = (state_q == S_CLEAR) ? '0 : {n_q, mean_new};

  lddn_ram #(
    .ADDR_BITS (BIN_BITS),
    .DATA_BITS (BIN_WORD_BITS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (bin_re),
    .raddr_i (bin_calc),
    .rdata_o (bin_rdata)
  );

  // running-mean step operands
  assign count_rd = bin_rdata[BIN_WORD_BITS-1 -: COUNT_BITS];
  assign mean_rd  = bin_rdata[MEAN_BITS-1:0];
  assign n_calc   = (count_rd == '1) ? count_rd : count_rd + 1'b1;
  assign dm       = {d_q, {MEAN_SHIFT{1'b0}}};
  assign diff_m   = DIFF_M_BITS'(dm) - DIFF_M_BITS'(mean_rd);
  assign mag_full = diff_m[DIFF_M_BITS-1] ? -diff_m : diff_m;
  assign dividend = DIVIDEND_BITS'(mag_full[MEAN_BITS-1:0]) + (n_calc >> 1);

  lddn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (n_calc),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // rounded step added to the mean, saturated to the mean range
  always_comb begin
    mean_ext = {{2{mean_q[MEAN_BITS-1]}}, mean_q};
    q_ext    = {2'b00, div_quo};
    if (neg_q) begin
      q_ext = -q_ext;
    end
    mean_sum = mean_ext + q_ext;
    if (mean_sum[MEAN_BITS+1] && (mean_sum[MEAN_BITS:MEAN_BITS-1] != 2'b11)) begin
      mean_new = {1'b1, {(MEAN_BITS-1){1'b0}}};
    end else if (!mean_sum[MEAN_BITS+1] && (mean_sum[MEAN_BITS:MEAN_BITS-1] != 2'b00)) begin
      mean_new = {1'b0, {(MEAN_BITS-1){1'b1}}};
    end else begin
      mean_new = mean_sum[MEAN_BITS-1:0];
    end
  end

  // gain products, one per cycle
  assign kc        = (gain_q > GAIN_BITS'(GAIN_ONE)) ? GAIN_BITS'(GAIN_ONE) : gain_q;
  assign one_minus = GAIN_BITS'(GAIN_ONE) - kc;
  assign prod_a    = $signed({1'b0, one_minus}) * d_q;
  assign prod_b    = $signed({1'b0, kc}) * mean_q;
  assign acc_d     = (ACC_BITS'(prod_q) <<< MEAN_SHIFT)
                   + (ACC_BITS'(prev_q) <<< BLEND_SHIFT)
                   + ACC_BITS'(1 << (BLEND_SHIFT - 1));

  // blend rounding and saturation
  assign total = acc_q + ACC_BITS'(prod_q);
  assign y     = total[ACC_BITS-1:BLEND_SHIFT];

  always_comb begin
    y_clip = 1'b0;
    y_sat  = y[SAMPLE_BITS-1:0];
    if (y[Y_BITS-1] && (y[Y_BITS-2:SAMPLE_BITS-1] != '1)) begin
      y_clip = 1'b1;
      y_sat  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (!y[Y_BITS-1] && (y[Y_BITS-2:SAMPLE_BITS-1] != '0)) begin
      y_clip = 1'b1;
      y_sat  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= s_axis_tdata;
      c_q <= chan_raddr;
    end
    if (state_q == S_BIN) begin
      prev_q <= prev_rd;
      d_q    <= d_calc;
      bin_q  <= bin_calc;
    end
    if (state_q == S_MUL) begin
      n_q    <= n_calc;
      neg_q  <= diff_m[DIFF_M_BITS-1];
      mean_q <= mean_rd;
      prod_q <= PROD_BITS'(prod_a);
    end
    if (state_q == S_MUL2) begin
      acc_q  <= acc_d;
      prod_q <= prod_b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= y_sat;
      out_chan_q   <= c_q;
      out_clip_q   <= y_clip;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tuser  = {out_clip_q, out_chan_q};

  // checks
  `LDDN_ASSERT_NXT(a_accept_starts_read, clk_i, rst_ni, accept, state_q == S_BIN)
  `LDDN_ASSERT_IMP(a_div_done_when_waiting, clk_i, rst_ni, div_done, state_q == S_DIV)
  `LDDN_ASSERT_IMP(a_emit_only_apply, clk_i, rst_ni, state_q == S_EMIT, learn_q == MODE_APPLY)

endmodule

`default_nettype wire

FILE: rtl/lddn_ram.sv
// generic simple dual-port ram with a registered read
`default_nettype none

module lddn_ram #(
  parameter int ADDR_BITS = 8,
  parameter int DATA_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem_q [0:(1 << ADDR_BITS)-1];
  logic [DATA_BITS-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/lddn_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none

module lddn_div
  import lddn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [DIVIDEND_BITS-1:0] dividend_i,
  input  logic [COUNT_BITS-1:0]    divisor_i,
  output logic                     done_o,
  output logic [QUO_BITS-1:0]      quotient_o
);

  localparam int STEP_BITS = $clog2(QUO_BITS);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [COUNT_BITS-1:0] rem_q;
  logic [COUNT_BITS-1:0] divisor_q;
  logic [QUO_BITS-1:0]   quo_q;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   trial_sub;
  logic                  fits;

  // trial subtraction of the divisor from the shifted remainder
  assign trial     = {rem_q, quo_q[QUO_BITS-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign fits      = trial >= {1'b0, divisor_q};

  // step counter and handshake
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_BITS'(QUO_BITS - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= COUNT_BITS'(dividend_i[DIVIDEND_BITS-1:QUO_BITS]);
      quo_q     <= dividend_i[QUO_BITS-1:0];
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_q <= {quo_q[QUO_BITS-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire
